// ===== sv/gpioirq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpioirq_pkg
// Shared types and constants of the gpio block with per-pin interrupts.
// ----------------------------------------------------------------------------
package gpioirq_pkg;

   localparam int DATA_WIDTH        = 32;
   localparam int PIN_COUNT_DEFAULT = 32;

   // bus access kinds
   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   // register map
   localparam logic [2:0] IDX_DIR  = 3'd0;
   localparam logic [2:0] IDX_OUT  = 3'd1;
   localparam logic [2:0] IDX_IN   = 3'd2;
   localparam logic [2:0] IDX_POL  = 3'd3;
   localparam logic [2:0] IDX_EDGE = 3'd4;
   localparam logic [2:0] IDX_EN   = 3'd5;
   localparam logic [2:0] IDX_PEND = 3'd6;

   typedef struct packed {
      logic [1:0]            mode;
      logic [2:0]            reg_index;
      logic [DATA_WIDTH-1:0] write_data;
      logic [DATA_WIDTH-1:0] pin_levels;
   } req_item_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] read_data;
      logic [DATA_WIDTH-1:0] pin_drive;
      logic [DATA_WIDTH-1:0] drive_enable;
      logic                  irq_line;
   } rsp_item_type;

   // live view of the register state, for checking
   typedef struct packed {
      logic [DATA_WIDTH-1:0] pin_drive;
      logic [DATA_WIDTH-1:0] drive_enable;
      logic                  irq_line;
   } status_type;

endpackage

// ===== sv/gpioirq_detect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpioirq_detect
// Per-pin interrupt condition: edge or level, selected polarity.
// ----------------------------------------------------------------------------
module gpioirq_detect #(
   parameter int PIN_COUNT = gpioirq_pkg::PIN_COUNT_DEFAULT
) (
   input  logic [PIN_COUNT-1:0] cur_levels,
   input  logic [PIN_COUNT-1:0] prev_levels,
   input  logic [PIN_COUNT-1:0] polarity,
   input  logic [PIN_COUNT-1:0] edge_select,
   output logic [PIN_COUNT-1:0] detected
);

   logic [PIN_COUNT-1:0] rising;
   logic [PIN_COUNT-1:0] falling;
   logic [PIN_COUNT-1:0] edge_hit;
   logic [PIN_COUNT-1:0] level_hit;

   assign rising    = cur_levels & ~prev_levels;
   assign falling   = ~cur_levels & prev_levels;
   assign edge_hit  = (rising & polarity) | (falling & ~polarity);
   // level matches polarity
   assign level_hit = ~(cur_levels ^ polarity);
   assign detected  = (edge_hit & edge_select) | (level_hit & ~edge_select);

endmodule

// ===== sv/gpioirq_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpioirq_regfile
// Register state, read mux, write decode and pending update for one beat.
// ----------------------------------------------------------------------------
module gpioirq_regfile #(
   parameter int PIN_COUNT = gpioirq_pkg::PIN_COUNT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  gpioirq_pkg::req_item_type item,
   output gpioirq_pkg::rsp_item_type result,
   output gpioirq_pkg::status_type   status
);

   logic [PIN_COUNT-1:0] dir_ff,  dir_in;
   logic [PIN_COUNT-1:0] out_ff,  out_in;
   logic [PIN_COUNT-1:0] pol_ff,  pol_in;
   logic [PIN_COUNT-1:0] edge_ff, edge_in;
   logic [PIN_COUNT-1:0] en_ff,   en_in;
   logic [PIN_COUNT-1:0] pend_ff, pend_in;
   logic [PIN_COUNT-1:0] prev_ff;

   logic [PIN_COUNT-1:0] cur;
   logic [PIN_COUNT-1:0] wdata;
   logic [PIN_COUNT-1:0] clear_mask;
   logic [PIN_COUNT-1:0] rd_value;
   logic [PIN_COUNT-1:0] detected;
   logic                 is_write;

   assign cur      = item.pin_levels[PIN_COUNT-1:0];
   assign wdata    = item.write_data[PIN_COUNT-1:0];
   assign is_write = (item.mode == gpioirq_pkg::MODE_WRITE);

   gpioirq_detect #(
      .PIN_COUNT(PIN_COUNT)
   ) u_detect (
      .cur_levels (cur),
      .prev_levels(prev_ff),
      .polarity   (pol_ff),
      .edge_select(edge_ff),
      .detected   (detected)
   );

   // read mux, state before this beat
   always_comb begin
      unique case (item.reg_index)
         gpioirq_pkg::IDX_DIR:  rd_value = dir_ff;
         gpioirq_pkg::IDX_OUT:  rd_value = out_ff;
         gpioirq_pkg::IDX_IN:   rd_value = cur;
         gpioirq_pkg::IDX_POL:  rd_value = pol_ff;
         gpioirq_pkg::IDX_EDGE: rd_value = edge_ff;
         gpioirq_pkg::IDX_EN:   rd_value = en_ff;
         gpioirq_pkg::IDX_PEND: rd_value = pend_ff;
         default:               rd_value = '0;
      endcase
   end

   // write decode
   always_comb begin
      dir_in     = dir_ff;
      out_in     = out_ff;
      pol_in     = pol_ff;
      edge_in    = edge_ff;
      en_in      = en_ff;
      clear_mask = '0;
      if (is_write) begin
         unique case (item.reg_index)
            gpioirq_pkg::IDX_DIR:  dir_in     = wdata;
            gpioirq_pkg::IDX_OUT:  out_in     = wdata;
            gpioirq_pkg::IDX_POL:  pol_in     = wdata;
            gpioirq_pkg::IDX_EDGE: edge_in    = wdata;
            gpioirq_pkg::IDX_EN:   en_in      = wdata;
            gpioirq_pkg::IDX_PEND: clear_mask = wdata;
            default:               ;
         endcase
      end
      // detection wins over clear
      pend_in = (pend_ff & ~clear_mask) | detected;
   end

   always_comb begin
      result.read_data    = (item.mode == gpioirq_pkg::MODE_READ) ?
                            gpioirq_pkg::DATA_WIDTH'(rd_value) : '0;
      result.pin_drive    = gpioirq_pkg::DATA_WIDTH'(out_in);
      result.drive_enable = gpioirq_pkg::DATA_WIDTH'(~dir_in);
      result.irq_line     = |(pend_in & en_in);
      status.pin_drive    = gpioirq_pkg::DATA_WIDTH'(out_ff);
      status.drive_enable = gpioirq_pkg::DATA_WIDTH'(~dir_ff);
      status.irq_line     = |(pend_ff & en_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff  <= '1;
         out_ff  <= '0;
         pol_ff  <= '0;
         edge_ff <= '0;
         en_ff   <= '0;
         pend_ff <= '0;
         prev_ff <= '0;
      end else if (step) begin
         dir_ff  <= dir_in;
         out_ff  <= out_in;
         pol_ff  <= pol_in;
         edge_ff <= edge_in;
         en_ff   <= en_in;
         pend_ff <= pend_in;
         prev_ff <= cur;
      end
   end

endmodule

// ===== sv/gpio_controller_with_pin_irq_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_controller_with_pin_irq_core
// 32-pin gpio with direction, output, polarity, edge select, enable and
// write-one-to-clear pending registers; per-pin edge/level interrupts.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake            | beat carries
//   --------+-----+----------------------+------------------------------------
//   req     | in  | req_valid/req_ready  | mode, reg_index, write_data, pins
//   rsp     | out | rsp_valid/rsp_ready  | read_data, pin_drive, drive_enable,
//           |     |                      | irq_line
//
// one beat per clock sustained while rsp_ready stays high; a beat passes the input
// register, then the result register, before rsp valid rises for it
// the register state advances when the input register hands its beat on to
// the result register, so a stall on rsp holds both the state and the pins'
// previous sample
// synchronous active-high reset: direction all ones inside PIN_COUNT, every
// other register zero, both pipeline registers empty
// bits at and above PIN_COUNT read and drive as zero
// ----------------------------------------------------------------------------
module gpio_controller_with_pin_irq_core #(
   parameter int PIN_COUNT = gpioirq_pkg::PIN_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_reg_index,
   input  logic [31:0] req_write_data,
   input  logic [31:0] req_pin_levels,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic [31:0] rsp_pin_drive,
   output logic [31:0] rsp_drive_enable,
   output logic        rsp_irq_line
);

   // input register
   logic                      in_valid_ff, in_valid_in;
   gpioirq_pkg::req_item_type in_item_ff;

   // result register
   logic                      out_valid_ff, out_valid_in;
   gpioirq_pkg::rsp_item_type out_item_ff;

   gpioirq_pkg::rsp_item_type result;
   gpioirq_pkg::status_type   status;
   logic                      advance;
   logic                      req_fire;

   // move the held beat into the result register when that slot is free
   // or being emptied this cycle
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   gpioirq_regfile #(
      .PIN_COUNT(PIN_COUNT)
   ) u_regfile (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .result(result),
      .status(status)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.mode       <= req_mode;
         in_item_ff.reg_index  <= req_reg_index;
         in_item_ff.write_data <= req_write_data;
         in_item_ff.pin_levels <= req_pin_levels;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = out_item_ff.read_data;
   assign rsp_pin_drive    = out_item_ff.pin_drive;
   assign rsp_drive_enable = out_item_ff.drive_enable;
   assign rsp_irq_line     = out_item_ff.irq_line;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------

   // a held result always matches the register state it was taken from
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pin_drive == status.pin_drive &&
                     rsp_drive_enable == status.drive_enable &&
                     rsp_irq_line == status.irq_line))
      else $error("result register out of step with register state");

   // a held request with a free result slot moves on next cycle
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_valid_ff) |=> rsp_valid)
      else $error("pending beat did not advance");

   // pins beyond PIN_COUNT are never driven
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_drive_enable >> PIN_COUNT) == 32'd0 &&
                     (rsp_pin_drive >> PIN_COUNT) == 32'd0))
      else $error("drive bits set above pin count");

   // the input slot is never refused while it is empty
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("request refused with empty input register");

endmodule

// ===== sim/gpio_irq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_irq_checker
// Watches both channels of the gpio block, runs a register-level prediction
// of every accepted request beat and compares each response beat with it.
// ----------------------------------------------------------------------------
module gpio_irq_checker #(
   parameter int PIN_COUNT = gpioirq_pkg::PIN_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_reg_index,
   input  logic [31:0] req_write_data,
   input  logic [31:0] req_pin_levels,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_read_data,
   input  logic [31:0] rsp_pin_drive,
   input  logic [31:0] rsp_drive_enable,
   input  logic        rsp_irq_line,
   output int          mismatch_count,
   output int          outstanding
);

   localparam logic [31:0] PIN_MASK = (PIN_COUNT >= 32) ? 32'hFFFF_FFFF :
                                      ((32'd1 << PIN_COUNT) - 32'd1);

   // predicted register file
   logic [31:0] dir_bits;
   logic [31:0] out_bits;
   logic [31:0] pol_bits;
   logic [31:0] edge_sel_bits;
   logic [31:0] en_bits;
   logic [31:0] pend_bits;
   logic [31:0] last_levels;

   gpioirq_pkg::rsp_item_type expected_rsp_q[$];

   function automatic gpioirq_pkg::rsp_item_type predict_access(
      gpioirq_pkg::req_item_type beat);
      gpioirq_pkg::rsp_item_type result;
      logic [31:0]  wdata;
      logic [31:0]  cur;
      logic [31:0]  rising;
      logic [31:0]  falling;
      logic [31:0]  edge_hit;
      logic [31:0]  level_hit;
      logic [31:0]  detected;
      wdata = beat.write_data & PIN_MASK;
      cur   = beat.pin_levels & PIN_MASK;
      result.read_data = '0;
      // reads see the registers before this beat's update
      if (beat.mode == gpioirq_pkg::MODE_READ) begin
         case (beat.reg_index)
            gpioirq_pkg::IDX_DIR:  result.read_data = dir_bits;
            gpioirq_pkg::IDX_OUT:  result.read_data = out_bits;
            gpioirq_pkg::IDX_IN:   result.read_data = cur;
            gpioirq_pkg::IDX_POL:  result.read_data = pol_bits;
            gpioirq_pkg::IDX_EDGE: result.read_data = edge_sel_bits;
            gpioirq_pkg::IDX_EN:   result.read_data = en_bits;
            gpioirq_pkg::IDX_PEND: result.read_data = pend_bits;
            default:               result.read_data = '0;
         endcase
      end
      // detection uses polarity and edge select from before the write
      rising    = cur & ~last_levels;
      falling   = ~cur & last_levels;
      edge_hit  = (rising & pol_bits) | (falling & ~pol_bits);
      level_hit = (cur & pol_bits) | (~cur & ~pol_bits);
      detected  = ((edge_hit & edge_sel_bits) | (level_hit & ~edge_sel_bits)) & PIN_MASK;
      if (beat.mode == gpioirq_pkg::MODE_WRITE) begin
         case (beat.reg_index)
            gpioirq_pkg::IDX_DIR:  dir_bits = wdata;
            gpioirq_pkg::IDX_OUT:  out_bits = wdata;
            gpioirq_pkg::IDX_POL:  pol_bits = wdata;
            gpioirq_pkg::IDX_EDGE: edge_sel_bits = wdata;
            gpioirq_pkg::IDX_EN:   en_bits = wdata;
            gpioirq_pkg::IDX_PEND: pend_bits = pend_bits & ~wdata;
            default: ;
         endcase
      end
      pend_bits   = (pend_bits | detected) & PIN_MASK;
      last_levels = cur;
      result.pin_drive    = out_bits;
      result.drive_enable = ~dir_bits & PIN_MASK;
      result.irq_line     = |(pend_bits & en_bits);
      return result;
   endfunction

   task automatic note_field(string field, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s: expected %08h, got %08h at %0t",
                     field, exp_val, act_val, $realtime);
      end
   endtask

   always @(posedge clock) begin
      gpioirq_pkg::rsp_item_type exp_rsp;
      gpioirq_pkg::req_item_type beat;
      if (reset) begin
         dir_bits       = PIN_MASK;
         out_bits       = '0;
         pol_bits       = '0;
         edge_sel_bits  = '0;
         en_bits        = '0;
         pend_bits      = '0;
         last_levels    = '0;
         expected_rsp_q.delete();
         mismatch_count = 0;
         outstanding    = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response beat with nothing expected at %0t", $realtime);
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               note_field("read_data", exp_rsp.read_data, rsp_read_data);
               note_field("pin_drive", exp_rsp.pin_drive, rsp_pin_drive);
               note_field("drive_enable", exp_rsp.drive_enable, rsp_drive_enable);
               note_field("irq_line", {31'd0, exp_rsp.irq_line}, {31'd0, rsp_irq_line});
            end
         end
         if (req_valid && req_ready) begin
            beat.mode       = req_mode;
            beat.reg_index  = req_reg_index;
            beat.write_data = req_write_data;
            beat.pin_levels = req_pin_levels;
            expected_rsp_q.push_back(predict_access(beat));
         end
         outstanding = expected_rsp_q.size();
      end
   end

endmodule

// ===== sim/gpio_controller_with_pin_irq_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_controller_with_pin_irq_core_test
// Drives bus accesses and pin levels into the gpio block under three idling
// mixes and one long response stall; a checker beside the block predicts
// and compares every response beat.
// ----------------------------------------------------------------------------
module gpio_controller_with_pin_irq_core_test;

   // codes the package leaves unnamed
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [2:0] IDX_UNUSED = 3'd7;

   localparam int RANDOM_PER_PHASE = 630;
   localparam int HOLD_OFF_CYCLES  = 200;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   logic [2:0]  req_reg_index;
   logic [31:0] req_write_data;
   logic [31:0] req_pin_levels;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_read_data;
   logic [31:0] rsp_pin_drive;
   logic [31:0] rsp_drive_enable;
   logic        rsp_irq_line;

   int mismatch_count;
   int outstanding;

   // idling mix of the current phase, in percent
   int send_idle_pct;
   int recv_idle_pct;

   // long response stall, asked for once by the stimulus
   logic hold_off_go;
   logic hold_off_done;
   int   hold_cycles;

   // bookkeeping for the summary
   int          beats_sent;
   int          reads_sent;
   int          writes_sent;
   logic [31:0] pin_state;

   gpio_controller_with_pin_irq_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_reg_index    (req_reg_index),
      .req_write_data   (req_write_data),
      .req_pin_levels   (req_pin_levels),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_pin_drive    (rsp_pin_drive),
      .rsp_drive_enable (rsp_drive_enable),
      .rsp_irq_line     (rsp_irq_line)
   );

   gpio_irq_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_reg_index    (req_reg_index),
      .req_write_data   (req_write_data),
      .req_pin_levels   (req_pin_levels),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_pin_drive    (rsp_pin_drive),
      .rsp_drive_enable (rsp_drive_enable),
      .rsp_irq_line     (rsp_irq_line),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // one request beat: optional idle gap, then hold valid until accepted
   // called and returning at a falling edge
   task automatic drive_access(input logic [1:0] mode, input logic [2:0] idx,
                               input logic [31:0] wdata, input logic [31:0] pins);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_reg_index  <= idx;
      req_write_data <= wdata;
      req_pin_levels <= pins;
      pin_state = pins;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
      if (mode == gpioirq_pkg::MODE_READ) reads_sent++;
      if (mode == gpioirq_pkg::MODE_WRITE) writes_sent++;
   endtask

   // random access: mostly register traffic with pins drifting a few bits
   // at a time, so edge and level detection both see real activity
   task automatic random_access();
      logic [1:0]  mode;
      logic [2:0]  idx;
      logic [31:0] wdata;
      logic [31:0] pins;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 30)      mode = gpioirq_pkg::MODE_IDLE;
      else if (pick < 55) mode = gpioirq_pkg::MODE_READ;
      else if (pick < 95) mode = gpioirq_pkg::MODE_WRITE;
      else                mode = MODE_SPARE;
      idx = ($urandom_range(19) == 0) ? IDX_UNUSED : 3'($urandom_range(6));
      case ($urandom_range(9))
         0:       wdata = 32'h0000_0000;
         1:       wdata = 32'hFFFF_FFFF;
         2:       wdata = 32'd1 << $urandom_range(31);
         default: wdata = $urandom;
      endcase
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: pins = pin_state ^ ($urandom & $urandom & $urandom);
         6:                pins = ~pin_state;
         7:                pins = $urandom;
         default:          pins = pin_state;
      endcase
      drive_access(mode, idx, wdata, pins);
   endtask

   // receiver: random ready, plus one long hold-off counted here
   initial begin
      rsp_ready     = 1'b0;
      hold_off_done = 1'b0;
      hold_cycles   = 0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_off_go && !hold_off_done) begin
            rsp_ready <= 1'b0;
            hold_cycles++;
            if (hold_cycles >= HOLD_OFF_CYCLES) hold_off_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = gpioirq_pkg::MODE_IDLE;
      req_reg_index  = gpioirq_pkg::IDX_DIR;
      req_write_data = '0;
      req_pin_levels = '0;
      hold_off_go    = 1'b0;
      send_idle_pct  = 36;
      recv_idle_pct  = 55;
      beats_sent     = 0;
      reads_sent     = 0;
      writes_sent    = 0;
      pin_state      = '0;

      // synchronous reset held, then released on a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      // first sample after reset: all pins high look like a rising edge
      drive_access(gpioirq_pkg::MODE_READ, gpioirq_pkg::IDX_DIR, 32'h0, 32'hFFFF_FFFF);
      drive_access(gpioirq_pkg::MODE_READ, gpioirq_pkg::IDX_PEND, 32'h0, 32'h0000_0000);
      drive_access(gpioirq_pkg::MODE_READ, gpioirq_pkg::IDX_IN, 32'h0, 32'hA5A5_5A5A);
      // input register is read only
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_IN, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
      drive_access(gpioirq_pkg::MODE_READ, gpioirq_pkg::IDX_IN, 32'h0, 32'h5A5A_A5A5);
      // direction and output extremes
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_DIR, 32'h0000_0000, 32'h0);
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_OUT, 32'hFFFF_FFFF, 32'h0);
      drive_access(gpioirq_pkg::MODE_READ, gpioirq_pkg::IDX_OUT, 32'h0, 32'h0);
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_DIR, 32'hFFFF_FFFF, 32'h0);
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_OUT, 32'h0000_0000, 32'h0);
      // rising-edge detection on all pins
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_POL, 32'hFFFF_FFFF, 32'h0);
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_EDGE, 32'hFFFF_FFFF, 32'h0);
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_PEND, 32'hFFFF_FFFF, 32'h0);
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_EN, 32'hFFFF_FFFF, 32'h0);
      drive_access(gpioirq_pkg::MODE_IDLE, gpioirq_pkg::IDX_DIR, 32'h0, 32'hFFFF_FFFF);
      drive_access(gpioirq_pkg::MODE_READ, gpioirq_pkg::IDX_PEND, 32'h0, 32'hFFFF_FFFF);
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_PEND, 32'hFFFF_FFFF, 32'h0);
      // clear and detect in the same beat: the bit must stay set
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_PEND, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF);
      // polarity flipped in the same beat as a falling edge: old polarity wins
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_POL, 32'h0000_0000,
                   32'h0000_0000);
      drive_access(gpioirq_pkg::MODE_READ, gpioirq_pkg::IDX_POL, 32'h0, 32'h0000_0000);
      // spare mode, unused register index
      drive_access(MODE_SPARE, gpioirq_pkg::IDX_PEND, 32'hFFFF_FFFF, 32'hFFFF_0000);
      drive_access(gpioirq_pkg::MODE_WRITE, IDX_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_0000);
      drive_access(gpioirq_pkg::MODE_READ, IDX_UNUSED, 32'h0, 32'hFFFF_0000);
      // back to level mode, interrupts off
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_EDGE, 32'h0000_0000,
                   32'h0000_FFFF);
      drive_access(gpioirq_pkg::MODE_WRITE, gpioirq_pkg::IDX_EN, 32'h0000_0000,
                   32'h0000_FFFF);

      // phase 1: sender idles 36 %, receiver 55 %, with the long stall
      hold_off_go <= 1'b1;
      repeat (RANDOM_PER_PHASE) random_access();
      // phase 2: the other way round
      send_idle_pct = 55;
      recv_idle_pct = 36;
      repeat (RANDOM_PER_PHASE) random_access();
      // phase 3: no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (RANDOM_PER_PHASE) random_access();
      req_valid <= 1'b0;

      // drain, then let the pipeline settle
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d accesses (%0d reads, %0d writes) under three idling mixes",
               beats_sent, reads_sent, writes_sent);
      $display("including a %0d-cycle response stall with the request side backed up",
               hold_cycles);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
